[src/nps_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the note stack.
package nps_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int HELD_W   = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_CLEAR    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EVICT,
        S_INSERT,
        S_MM_INIT,
        S_MM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic clear;
        logic scan_inc;
        logic rm_at_idx;
        logic rm_last;
        logic insert;
        logic mm_rst;
        logic mm_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             at_end;
        logic             match;
        logic             full;
        logic             out_busy;
    } t_status;

endpackage

[src/nps_ctrl.sv]
// Controller state machine that sequences search, removal, insertion and the pitch scan.
module nps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  nps_pkg::t_status i_status,
    output nps_pkg::t_cmd    o_cmd
);
    import nps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.act)
                    ACT_NOTE_ON, ACT_NOTE_OFF: begin
                        n_state = S_SCAN;
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_MM_INIT;
                    end
                    default: begin
                        n_state = S_MM_INIT;
                    end
                endcase
            end
            S_SCAN: begin
                // Walk from the most recent entry toward the oldest looking for the note.
                if (i_status.at_end || i_status.match) begin
                    o_cmd.rm_at_idx = !i_status.at_end;
                    n_state = (i_status.act == ACT_NOTE_ON) ? S_EVICT : S_MM_INIT;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_EVICT: begin
                o_cmd.rm_last = i_status.full;
                n_state       = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_MM_INIT;
            end
            S_MM_INIT: begin
                o_cmd.mm_rst = 1'b1;
                n_state      = S_MM;
            end
            S_MM: begin
                if (i_status.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mm_acc = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/nps_datapath.sv]
// Datapath: recency-ordered note store, scan index, pitch extremes and the result register.
module nps_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  nps_pkg::t_cmd           i_cmd,
    output nps_pkg::t_status        o_status,
    input  logic [nps_pkg::ACT_W-1:0]  i_action,
    input  logic [nps_pkg::NOTE_W-1:0] i_note,
    input  logic [nps_pkg::VEL_W-1:0]  i_velocity,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_any_held,
    output logic [nps_pkg::NOTE_W-1:0] o_recent_note,
    output logic [nps_pkg::VEL_W-1:0]  o_recent_velocity,
    output logic [nps_pkg::HELD_W-1:0] o_held_count,
    output logic [nps_pkg::NOTE_W-1:0] o_lowest_note,
    output logic [nps_pkg::NOTE_W-1:0] o_highest_note
);
    import nps_pkg::*;

    // Entry 0 is the most recent note; entries at and above r_count are stale.
    logic [NOTE_W-1:0] r_note [CAPACITY];
    logic [VEL_W-1:0]  r_vel  [CAPACITY];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [ACT_W-1:0]  r_act;
    logic [NOTE_W-1:0] r_key_note;
    logic [VEL_W-1:0]  r_key_vel;
    logic [NOTE_W-1:0] r_lo;
    logic [NOTE_W-1:0] r_hi;
    logic              r_out_valid;
    logic              r_any;
    logic [NOTE_W-1:0] r_recent_note;
    logic [VEL_W-1:0]  r_recent_vel;
    logic [HELD_W-1:0] r_held;
    logic [NOTE_W-1:0] r_out_lo;
    logic [NOTE_W-1:0] r_out_hi;

    logic [NOTE_W-1:0] rd_note;
    logic              any_now;

    assign rd_note = r_note[r_idx[IDX_W-1:0]];
    assign any_now = (r_count != '0);

    assign o_status.act      = r_act;
    assign o_status.at_end   = (r_idx == r_count);
    assign o_status.match    = (rd_note == r_key_note);
    assign o_status.full     = (r_count == CNT_W'(CAPACITY));
    assign o_status.out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rm_at_idx) begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
                if (CNT_W'(j) >= r_idx) begin
                    r_note[j] <= r_note[j + 1];
                    r_vel[j]  <= r_vel[j + 1];
                end
            end
        end else if (i_cmd.insert) begin
            for (int j = 1; j < CAPACITY; j++) begin
                r_note[j] <= r_note[j - 1];
                r_vel[j]  <= r_vel[j - 1];
            end
            r_note[0] <= r_key_note;
            r_vel[0]  <= r_key_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act      <= i_action;
            r_key_note <= i_note;
            r_key_vel  <= i_velocity;
        end
        if (i_cmd.latch || i_cmd.mm_rst) begin
            r_idx <= '0;
        end else if (i_cmd.scan_inc || i_cmd.mm_acc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.mm_rst) begin
            r_lo <= '1;
            r_hi <= '0;
        end else if (i_cmd.mm_acc) begin
            if (rd_note < r_lo) begin
                r_lo <= rd_note;
            end
            if (rd_note > r_hi) begin
                r_hi <= rd_note;
            end
        end
        if (i_cmd.out_load) begin
            r_any         <= any_now;
            r_recent_note <= any_now ? r_note[0] : '0;
            r_recent_vel  <= any_now ? r_vel[0] : '0;
            r_held        <= HELD_W'(r_count);
            r_out_lo      <= any_now ? r_lo : '0;
            r_out_hi      <= any_now ? r_hi : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.rm_at_idx || i_cmd.rm_last) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_any_held        = r_any;
    assign o_recent_note     = r_recent_note;
    assign o_recent_velocity = r_recent_vel;
    assign o_held_count      = r_held;
    assign o_lowest_note     = r_out_lo;
    assign o_highest_note    = r_out_hi;

endmodule

[src/note_priority_stack.sv]
// Top level of the last-note-priority held-note stack for a monophonic voice.
// A note on or off first searches the list and removes a match; a note on then evicts if full
// and inserts. Every request ends with the pitch minimum/maximum scan through the one read port
// before its result enters the result register. A new request is taken only after that load,
// and the load waits while the output still holds a result that has not been taken.
// Reset (synchronous, active low) empties the stack, idles the controller and drops o_out_valid.
module note_priority_stack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [nps_pkg::ACT_W-1:0]  i_action,
    input  logic [nps_pkg::NOTE_W-1:0] i_note,
    input  logic [nps_pkg::VEL_W-1:0]  i_velocity,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_any_held,
    output logic [nps_pkg::NOTE_W-1:0] o_recent_note,
    output logic [nps_pkg::VEL_W-1:0]  o_recent_velocity,
    output logic [nps_pkg::HELD_W-1:0] o_held_count,
    output logic [nps_pkg::NOTE_W-1:0] o_lowest_note,
    output logic [nps_pkg::NOTE_W-1:0] o_highest_note
);
    import nps_pkg::*;

    // The held notes live in a recency-ordered list: entry 0 is the most recent note and
    // the oldest sits at the end, so eviction of the least recent note is just a drop of
    // the last entry. A note on searches the list for a copy of the same note, removes it
    // by closing the gap, evicts when the list is full, then pushes the new note at the
    // front. A note off only searches and removes. Because no note is held twice, the
    // lowest and highest held pitches follow from one pass over the list after the update.
    // The result register decouples the output side, so a new request is taken while the
    // previous result still waits to be taken.

    t_cmd    cmd;
    t_status status;

    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nps_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_action          (i_action),
        .i_note            (i_note),
        .i_velocity        (i_velocity),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_any_held        (o_any_held),
        .o_recent_note     (o_recent_note),
        .o_recent_velocity (o_recent_velocity),
        .o_held_count      (o_held_count),
        .o_lowest_note     (o_lowest_note),
        .o_highest_note    (o_highest_note)
    );

endmodule
